// ----- sv/nsq_pkg.sv -----
// Shared types, constants and helpers of the nine-slice quad layout unit.
// Used by every module of the block but nsq_checker; depends on nothing.
package nsq_pkg;

    // Field widths
    localparam int POS_W  = 16;  // Q12.4 and Q2.14 output fields
    localparam int EDGE_W = 18;  // destination edge after outset
    localparam int SRC_W  = 26;  // texture coordinate after normalization
    localparam int NUM_W  = 48;  // divider dividend and quotient
    localparam int DEN_W  = 34;  // divider divisor
    localparam int STEP_W = 5;   // divider double-step count
    localparam int APP_W  = 50;  // wide intermediate before saturation
    localparam int D_W    = 49;  // aspect correction term

    // Job queue depth between front and back
    localparam int QDEPTH = 2;

    // Divider step counts (two quotient bits per step)
    localparam logic [STEP_W-1:0] NORM_STEPS = 5'd13;
    localparam logic [STEP_W-1:0] ASP_STEPS  = 5'd24;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SLICE_MODE   = 3'd0,
        CFG_ASPECT_MODE  = 3'd1,
        CFG_ALIGN_X      = 3'd2,
        CFG_ALIGN_Y      = 3'd3,
        CFG_DEST_OFS     = 3'd4,
        CFG_SRC_OFS      = 3'd5,
        CFG_OUTSET       = 3'd6,
        CFG_TEXTURE_SIZE = 3'd7
    } t_cfg_idx;

    // Mode codes
    localparam logic [1:0] SLICE_NONE = 2'd0;
    localparam logic [1:0] ASP_FIT    = 2'd1;
    localparam logic [1:0] ASP_COVER  = 2'd2;
    localparam logic [1:0] ALN_MIN    = 2'd0;
    localparam logic [1:0] ALN_MAX    = 2'd2;

    typedef struct packed {
        logic [1:0]  slice_mode;
        logic [1:0]  aspect_mode;
        logic [1:0]  align_x;
        logic [1:0]  align_y;
        logic [63:0] dest_ofs;
        logic [63:0] src_ofs;
        logic [63:0] outset;
        logic [15:0] tex_w;
        logic [15:0] tex_h;
    } t_cfg;

    // One classified layout request: outset edges and source edges
    // (source order left, top, right, bottom, before the v flip)
    typedef struct packed {
        logic signed [EDGE_W-1:0] l;
        logic signed [EDGE_W-1:0] t;
        logic signed [EDGE_W-1:0] r;
        logic signed [EDGE_W-1:0] b;
        logic [3:0][SRC_W-1:0]    s;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM_GO,
        F_NORM_WAIT,
        F_MUL,
        F_ASPECT,
        F_DIV_WAIT,
        F_APPLY,
        F_PUSH
    } t_front_state;

    // Clamp a wide value to a signed 16-bit field
    function automatic logic signed [POS_W-1:0] sat16(input logic signed [APP_W-1:0] v);
        logic signed [POS_W-1:0] res;
        if (v > 50'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -50'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/nine_slice_quad_layout_unit.sv -----
// Top level of the nine-slice quad layout unit: configuration registers, front
// end, job queue, back end. Depends on nsq_pkg, nsq_front, nsq_queue, nsq_back.
//
//  channel   direction  accepts when                    carries
//  s_axis    in         s_axis_tvalid & s_axis_tready   one layout request
//  m_axis    out        m_axis_tvalid & m_axis_tready   one quad, tlast on final
//  cfg       in         i_cfg_we                        one register write
//
// Front: a texel source adds 4 divisions; fit/cover (no-slice mode only)
// adds at most one aspect division, both on the shared radix-4 divider.
// The back emits one quad a cycle while the output is not stalled (1 or
// up to 9 per job) and takes the next job after the last quad of a job.
// Reset is synchronous, active low, and needs no clearing pass.
// A two-job queue lets the front accept requests in an output stall until full.
module nine_slice_quad_layout_unit #(
    parameter int MAX_QUADS = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // dst_left, dst_top, dst_right, dst_bottom,
    // src_left, src_top, src_right, src_bottom (16 bits each)
    input  logic [127:0]  s_axis_tdata,
    // src_normalized
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // quad_index (4), pos_left, pos_top, pos_right, pos_bottom,
    // tex_left, tex_top, tex_right, tex_bottom (16 each), 4 zero bits
    output logic [135:0]  m_axis_tdata,
    output logic          m_axis_tlast
);
    nsq_pkg::t_cfg    r_cfg;
    nsq_pkg::t_job    push_job, head_job;
    nsq_pkg::t_q_stat q_stat;
    logic             push, pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slice_mode  <= 2'd0;
            r_cfg.aspect_mode <= 2'd0;
            r_cfg.align_x     <= 2'd1;
            r_cfg.align_y     <= 2'd1;
            r_cfg.dest_ofs    <= '0;
            r_cfg.src_ofs     <= '0;
            r_cfg.outset      <= '0;
            r_cfg.tex_w       <= 16'd1;
            r_cfg.tex_h       <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (nsq_pkg::t_cfg_idx'(i_cfg_index))
                nsq_pkg::CFG_SLICE_MODE:   r_cfg.slice_mode  <= i_cfg_data[1:0];
                nsq_pkg::CFG_ASPECT_MODE:  r_cfg.aspect_mode <= i_cfg_data[1:0];
                nsq_pkg::CFG_ALIGN_X:      r_cfg.align_x     <= i_cfg_data[1:0];
                nsq_pkg::CFG_ALIGN_Y:      r_cfg.align_y     <= i_cfg_data[1:0];
                nsq_pkg::CFG_DEST_OFS:     r_cfg.dest_ofs    <= i_cfg_data;
                nsq_pkg::CFG_SRC_OFS:      r_cfg.src_ofs     <= i_cfg_data;
                nsq_pkg::CFG_OUTSET:       r_cfg.outset      <= i_cfg_data;
                nsq_pkg::CFG_TEXTURE_SIZE: begin
                    r_cfg.tex_w <= i_cfg_data[15:0];
                    r_cfg.tex_h <= i_cfg_data[31:16];
                end
                default: ;
            endcase
        end
    end

    nsq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    nsq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    nsq_back #(
        .MAX_QUADS (MAX_QUADS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (head_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- sv/nsq_div.sv -----
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on nsq_pkg for widths.
module nsq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [nsq_pkg::NUM_W-1:0]   i_dividend,
    input  logic [nsq_pkg::DEN_W-1:0]   i_divisor,
    input  logic [nsq_pkg::STEP_W-1:0]  i_steps,
    output logic                        o_done,
    output logic [nsq_pkg::NUM_W-1:0]   o_quot
);
    localparam int NW = nsq_pkg::NUM_W;
    localparam int DW = nsq_pkg::DEN_W;

    logic [DW-1:0]                r_rem;
    logic [DW-1:0]                r_den;
    logic [NW-1:0]                r_quo;
    logic [nsq_pkg::STEP_W-1:0]   r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [DW:0]                  t1;
    logic [DW:0]                  t2;
    logic [DW-1:0]                rem1;
    logic [DW-1:0]                n_rem;
    logic [NW-1:0]                n_quo;
    logic                         bit1;
    logic                         bit2;

    // Two compare-subtract steps
    always_comb begin
        t1   = {r_rem, r_quo[NW-1]};
        bit1 = (t1 >= {1'b0, r_den});
        rem1 = bit1 ? DW'(t1 - {1'b0, r_den}) : t1[DW-1:0];
        t2   = {rem1, r_quo[NW-2]};
        bit2 = (t2 >= {1'b0, r_den});
        n_rem = bit2 ? DW'(t2 - {1'b0, r_den}) : t2[DW-1:0];
        n_quo = {r_quo[NW-3:0], bit1, bit2};
    end

    // Load on start, iterate while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- sv/nsq_front.sv -----
// Front end: accepts layout requests, applies the outset, normalizes the
// source and applies the aspect rule. Depends on nsq_pkg and nsq_div.
module nsq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nsq_pkg::t_cfg        i_cfg,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [127:0]         i_tdata,
    input  logic                 i_tuser,
    input  nsq_pkg::t_q_stat     i_q_stat,
    output logic                 o_push,
    output nsq_pkg::t_job        o_job
);
    localparam int EW = nsq_pkg::EDGE_W;
    localparam int SW = nsq_pkg::SRC_W;
    localparam int AW = nsq_pkg::APP_W;

    nsq_pkg::t_front_state r_state, n_state;
    nsq_pkg::t_job         r_job;
    logic [1:0]            r_k;
    logic [nsq_pkg::DEN_W-1:0] r_cx, r_cy;
    logic                  r_axis_y;
    logic signed [nsq_pkg::D_W-1:0] r_d;

    logic        accept;
    logic        need_aspect;
    logic [15:0] tw_e, th_e;
    logic        div_start;
    logic [nsq_pkg::NUM_W-1:0]  div_dividend;
    logic [nsq_pkg::DEN_W-1:0]  div_divisor;
    logic [nsq_pkg::STEP_W-1:0] div_steps;
    logic        div_done;
    logic [nsq_pkg::NUM_W-1:0]  div_quot;
    logic [SW-1:0] raw, prod, mag, q26;
    logic        neg;
    logic signed [EW:0] dx, dy;
    logic [EW-1:0] dw, dh;
    logic        fit, x_scale, y_scale;
    logic [nsq_pkg::DEN_W-1:0] den;
    logic signed [AW-1:0] d50, dhalf, lead, trail, a0, a1, a2, a3;
    nsq_pkg::t_front_state start_state;

    assign accept      = i_tvalid && o_tready;
    assign need_aspect = (i_cfg.slice_mode == nsq_pkg::SLICE_NONE) &&
                         (i_cfg.aspect_mode == nsq_pkg::ASP_FIT ||
                          i_cfg.aspect_mode == nsq_pkg::ASP_COVER);
    assign tw_e = (i_cfg.tex_w == 16'd0) ? 16'd1 : i_cfg.tex_w;
    assign th_e = (i_cfg.tex_h == 16'd0) ? 16'd1 : i_cfg.tex_h;

    // Normalization operand of the current source edge
    always_comb begin
        raw  = r_job.s[r_k];
        neg  = raw[SW-1];
        prod = {raw[15:0], 10'b0};
        mag  = neg ? SW'(-prod) : prod;
        q26  = div_quot[SW-1:0];
    end

    // Aspect compare
    always_comb begin
        dx = (EW+1)'(r_job.r) - (EW+1)'(r_job.l);
        dy = (EW+1)'(r_job.b) - (EW+1)'(r_job.t);
        dw = dx[EW] ? EW'(-dx) : dx[EW-1:0];
        dh = dy[EW] ? EW'(-dy) : dy[EW-1:0];
        fit     = (i_cfg.aspect_mode == nsq_pkg::ASP_FIT);
        x_scale = fit ? (r_cx <= r_cy) : (r_cx >= r_cy);
        y_scale = fit ? (r_cy <= r_cx) : (r_cy >= r_cx);
        den     = x_scale ? r_cx : r_cy;
    end

    // Correction terms per edge; halve toward zero
    always_comb begin
        logic [1:0] aln;
        aln   = r_axis_y ? i_cfg.align_y : i_cfg.align_x;
        d50   = AW'(r_d);
        dhalf = (d50 < 0) ? -((-d50) >>> 1) : (d50 >>> 1);
        lead  = (aln == nsq_pkg::ALN_MAX) ? d50 :
                (aln == nsq_pkg::ALN_MIN) ? '0 : dhalf;
        trail = (aln == nsq_pkg::ALN_MIN) ? d50 :
                (aln == nsq_pkg::ALN_MAX) ? '0 : dhalf;
        a0 = AW'($signed(r_job.s[0])) - (r_axis_y ? AW'(0) : lead);
        a2 = AW'($signed(r_job.s[2])) + (r_axis_y ? AW'(0) : trail);
        a3 = AW'($signed(r_job.s[3])) + (r_axis_y ? lead  : AW'(0));
        a1 = AW'($signed(r_job.s[1])) - (r_axis_y ? trail : AW'(0));
    end

    // Next state
    always_comb begin
        start_state = !i_tuser ? nsq_pkg::F_NORM_GO :
                      need_aspect ? nsq_pkg::F_MUL : nsq_pkg::F_PUSH;
        n_state = r_state;
        unique case (r_state)
            nsq_pkg::F_IDLE:      if (accept) n_state = start_state;
            nsq_pkg::F_NORM_GO:   n_state = nsq_pkg::F_NORM_WAIT;
            nsq_pkg::F_NORM_WAIT: begin
                if (div_done) begin
                    if (r_k == 2'd3) begin
                        n_state = need_aspect ? nsq_pkg::F_MUL : nsq_pkg::F_PUSH;
                    end else begin
                        n_state = nsq_pkg::F_NORM_GO;
                    end
                end
            end
            nsq_pkg::F_MUL:       n_state = nsq_pkg::F_ASPECT;
            nsq_pkg::F_ASPECT: begin
                if (x_scale && y_scale) begin
                    n_state = nsq_pkg::F_PUSH;
                end else if (den == '0) begin
                    n_state = nsq_pkg::F_APPLY;
                end else begin
                    n_state = nsq_pkg::F_DIV_WAIT;
                end
            end
            nsq_pkg::F_DIV_WAIT:  if (div_done) n_state = nsq_pkg::F_APPLY;
            nsq_pkg::F_APPLY:     n_state = nsq_pkg::F_PUSH;
            nsq_pkg::F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = accept ? start_state : nsq_pkg::F_IDLE;
                end
            end
            default:              n_state = nsq_pkg::F_IDLE;
        endcase
    end

    // Handshake and divider control
    always_comb begin
        o_tready     = (r_state == nsq_pkg::F_IDLE) ||
                       (r_state == nsq_pkg::F_PUSH && !i_q_stat.full);
        o_push       = (r_state == nsq_pkg::F_PUSH) && !i_q_stat.full;
        div_start    = 1'b0;
        div_dividend = {mag, 22'b0};
        div_divisor  = nsq_pkg::DEN_W'(r_k[0] ? th_e : tw_e);
        div_steps    = nsq_pkg::NORM_STEPS;
        unique case (r_state)
            nsq_pkg::F_NORM_GO: div_start = 1'b1;
            nsq_pkg::F_ASPECT: begin
                div_start    = !(x_scale && y_scale) && (den != '0);
                div_dividend = {(x_scale ? r_cy : r_cx), 14'b0};
                div_divisor  = den;
                div_steps    = nsq_pkg::ASP_STEPS;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsq_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.l <= EW'($signed(i_tdata[15:0]))   - EW'(i_cfg.outset[15:0]);
            r_job.t <= EW'($signed(i_tdata[31:16]))  - EW'(i_cfg.outset[31:16]);
            r_job.r <= EW'($signed(i_tdata[47:32]))  + EW'(i_cfg.outset[47:32]);
            r_job.b <= EW'($signed(i_tdata[63:48]))  + EW'(i_cfg.outset[63:48]);
            r_job.s[0] <= SW'($signed(i_tdata[79:64]));
            r_job.s[1] <= SW'($signed(i_tdata[95:80]));
            r_job.s[2] <= SW'($signed(i_tdata[111:96]));
            r_job.s[3] <= SW'($signed(i_tdata[127:112]));
            r_k <= 2'd0;
        end else begin
            unique case (r_state)
                nsq_pkg::F_NORM_WAIT: begin
                    if (div_done) begin
                        r_job.s[r_k] <= neg ? SW'(-q26) : q26;
                        r_k <= r_k + 2'd1;
                    end
                end
                nsq_pkg::F_MUL: begin
                    r_cx <= nsq_pkg::DEN_W'(dw * th_e);
                    r_cy <= nsq_pkg::DEN_W'(dh * tw_e);
                end
                nsq_pkg::F_ASPECT: begin
                    r_axis_y <= x_scale;
                    r_d      <= 49'sh100_0000_0000;
                end
                nsq_pkg::F_DIV_WAIT: begin
                    if (div_done) begin
                        r_d <= $signed({1'b0, div_quot}) - 49'sd16384;
                    end
                end
                nsq_pkg::F_APPLY: begin
                    r_job.s[0] <= SW'(nsq_pkg::sat16(a0));
                    r_job.s[1] <= SW'(nsq_pkg::sat16(a1));
                    r_job.s[2] <= SW'(nsq_pkg::sat16(a2));
                    r_job.s[3] <= SW'(nsq_pkg::sat16(a3));
                end
                default: ;
            endcase
        end
    end

    assign o_job = r_job;

    nsq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

endmodule

// ----- sv/nsq_queue.sv -----
// Short job queue between the front and the back end.
// Depends on nsq_pkg for the job type and depth.
module nsq_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nsq_pkg::t_job     i_job,
    input  logic              i_pop,
    output nsq_pkg::t_job     o_job,
    output nsq_pkg::t_q_stat  o_stat
);
    localparam int PW = $clog2(nsq_pkg::QDEPTH);

    nsq_pkg::t_job r_slot [nsq_pkg::QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_count;

    assign o_stat.full  = (r_count == (PW+1)'(nsq_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_job        = r_slot[r_rp];

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= PW'(r_wp + 1'b1);
            if (i_pop)  r_rp <= PW'(r_rp + 1'b1);
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

endmodule

// ----- sv/nsq_back.sv -----
// Back end: walks the slice grid of one job and emits one quad per cycle
// while the output is not stalled, through an output register. Depends on nsq_pkg.
module nsq_back #(
    parameter int MAX_QUADS = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsq_pkg::t_cfg     i_cfg,
    input  nsq_pkg::t_job     i_job,
    input  nsq_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [135:0]      o_tdata,
    output logic              o_tlast
);
    localparam int AW = nsq_pkg::APP_W;

    nsq_pkg::t_job r_job;
    logic          r_active;
    logic [1:0]    r_ix, r_iy;
    logic [3:0]    r_cnt;
    logic          r_ovalid;
    logic [135:0]  r_odata;
    logic          r_olast;

    logic signed [AW-1:0] px [4];
    logic signed [AW-1:0] py [4];
    logic signed [AW-1:0] ux [4];
    logic signed [AW-1:0] uy [4];
    logic       mode0, fill, load, is_last;
    logic [1:0] xlo, xhi, ylo, yhi, n_ix, n_iy;

    assign mode0 = (i_cfg.slice_mode == nsq_pkg::SLICE_NONE);
    assign fill  = i_cfg.slice_mode[1];
    assign o_pop = !r_active && !i_q_stat.empty;
    assign load  = r_active && (!r_ovalid || i_tready);

    // Grid lines on screen and in the texture (v flipped here)
    always_comb begin
        px[0] = AW'(r_job.l);
        px[1] = AW'(r_job.l) + AW'(i_cfg.dest_ofs[15:0]);
        px[2] = AW'(r_job.r) - AW'(i_cfg.dest_ofs[47:32]);
        px[3] = AW'(r_job.r);
        py[0] = AW'(r_job.t);
        py[1] = AW'(r_job.t) + AW'(i_cfg.dest_ofs[31:16]);
        py[2] = AW'(r_job.b) - AW'(i_cfg.dest_ofs[63:48]);
        py[3] = AW'(r_job.b);
        ux[0] = AW'($signed(r_job.s[0]));
        ux[1] = AW'($signed(r_job.s[0])) + AW'(i_cfg.src_ofs[15:0]);
        ux[2] = AW'($signed(r_job.s[2])) - AW'(i_cfg.src_ofs[47:32]);
        ux[3] = AW'($signed(r_job.s[2]));
        uy[0] = AW'($signed(r_job.s[3]));
        uy[1] = AW'($signed(r_job.s[3])) - AW'(i_cfg.src_ofs[31:16]);
        uy[2] = AW'($signed(r_job.s[1])) + AW'(i_cfg.src_ofs[63:48]);
        uy[3] = AW'($signed(r_job.s[1]));
    end

    // Cell selection and the next grid position
    always_comb begin
        xlo = mode0 ? 2'd0 : r_ix;
        xhi = mode0 ? 2'd3 : r_ix + 2'd1;
        ylo = mode0 ? 2'd0 : r_iy;
        yhi = mode0 ? 2'd3 : r_iy + 2'd1;
        is_last = mode0 || (r_cnt == 4'(MAX_QUADS - 1)) ||
                  (r_ix == 2'd2 && r_iy == 2'd2);
        if (r_iy == 2'd2) begin
            n_ix = r_ix + 2'd1;
            n_iy = 2'd0;
        end else begin
            n_ix = r_ix;
            n_iy = r_iy + 2'd1;
        end
        // skip the center cell unless filled
        if (n_ix == 2'd1 && n_iy == 2'd1 && !fill) begin
            n_iy = 2'd2;
        end
    end

    // Job and grid walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_job    <= i_job;
                r_ix     <= 2'd0;
                r_iy     <= 2'd0;
                r_cnt    <= 4'd0;
            end else if (load) begin
                r_ix  <= n_ix;
                r_iy  <= n_iy;
                r_cnt <= r_cnt + 4'd1;
                if (is_last) r_active <= 1'b0;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_odata <= {4'b0,
                        nsq_pkg::sat16(uy[yhi]), nsq_pkg::sat16(ux[xhi]),
                        nsq_pkg::sat16(uy[ylo]), nsq_pkg::sat16(ux[xlo]),
                        nsq_pkg::sat16(py[yhi]), nsq_pkg::sat16(px[xhi]),
                        nsq_pkg::sat16(py[ylo]), nsq_pkg::sat16(px[xlo]),
                        r_cnt};
            r_olast <= is_last;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tlast  = r_olast;

endmodule

// ----- sv/nsq_checker.sv -----
// Port-level checks of the nine-slice quad layout unit, bound to the top.
// Depends on nine_slice_quad_layout_unit.
module nsq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [135:0]  m_axis_tdata,
    input logic          m_axis_tlast
);
    // Output register empties on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Hold a stalled quad
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled quad changed");

    // At most nine quads per layout
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
        else $error("quad index beyond grid");

    // The ninth quad always closes the layout
    a_ninth_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[3:0] < 4'd8)
        else $error("ninth quad not marked last");

endmodule

bind nine_slice_quad_layout_unit nsq_checker u_nsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
